// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int CURSOR_W = 11;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              write;
    logic              scroll;
    logic [CHAR_W-1:0] wdata;
  } cur_ctl_t;

endpackage

// File: rtl/text_console_char_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_core
// Text-mode character buffer with cursor, scroll and cell read-back.
//
// Input beats carry operation, char_code and read_address on a valid/ready
// channel; every input beat yields exactly one output beat with read_char,
// cursor_pos and scrolled. A put stores or interprets one character at the
// cursor; a read returns the cell at read_address (zero beyond the screen).
// A plain put, backspace, newline or return passes from idle through the
// done state into the output register; a read first takes a read state for
// the registered RAM, a tab a tab state that writes its four spaces. A scroll
// copies the cells up a row, one cell per cycle, then fills the bottom row
// with spaces. One item is in work at a time; the next is taken once the
// result sits in the output register.
// After reset the block clears the cell memory to zero, one cell per cycle,
// with in_ready_o low. The cursor resets to zero.
// When the receiver stalls, the result holds in the output register and the
// block takes one more item, finishing it only once the register frees.
// ----------------------------------------------------------------------------
module text_console_char_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [ADDR_W-1:0]   read_address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CHAR_W-1:0]   read_char_o,
  output logic [CURSOR_W-1:0] cursor_pos_o,
  output logic                scrolled_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CURW  = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_TAB, S_COPY, S_DRAIN, S_FILL, S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [CURW-1:0]      cursor_q, cursor_d;
  logic [CLW-1:0]       col_q, col_d;
  logic [CURW-1:0]      ptr_q, ptr_d;
  logic [CURW-1:0]      dst_q, dst_d;
  logic                 pend_q, pend_d;
  logic [1:0]           tab_left_q, tab_left_d;
  logic                 tab_more_q, tab_more_d;
  logic                 scr_q, scr_d;
  logic                 rd_ok_q, rd_ok_d;
  logic [CHAR_W-1:0]    res_char_q, res_char_d;
  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    out_char_q, out_char_d;
  logic [CURW-1:0]      out_cur_q, out_cur_d;
  logic                 out_scr_q, out_scr_d;

  logic                 we;
  logic [CURW-1:0]      waddr;
  logic [CHAR_W-1:0]    wdata;
  logic [CURW-1:0]      raddr;
  logic [CHAR_W-1:0]    rdata;

  logic [CHAR_W-1:0]    cu_char;
  logic [CURW-1:0]      cu_cursor;
  logic [CLW-1:0]       cu_col;
  logic [CURW-1:0]      cu_waddr;
  cur_ctl_t             cu_ctl;

  logic [CURW+ADDR_W-1:0]   rd_ext;
  logic [CURW+CURSOR_W-1:0] cur_ext;
  logic                     ptr_last;

  tcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .cursor_i (cursor_q),
    .col_i    (col_q),
    .char_i   (cu_char),
    .cursor_o (cu_cursor),
    .col_o    (cu_col),
    .waddr_o  (cu_waddr),
    .ctl_o    (cu_ctl)
  );

  assign rd_ext   = (CURW+ADDR_W)'(read_address_i);
  assign ptr_last = (ptr_q == CURW'(CELLS - 1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    ptr_d       = ptr_q;
    dst_d       = dst_q;
    pend_d      = pend_q;
    tab_left_d  = tab_left_q;
    tab_more_d  = tab_more_q;
    scr_d       = scr_q;
    rd_ok_d     = rd_ok_q;
    res_char_d  = res_char_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_char_d  = out_char_q;
    out_cur_d   = out_cur_q;
    out_scr_d   = out_scr_q;
    we          = 1'b0;
    waddr       = cu_waddr;
    wdata       = cu_ctl.wdata;
    raddr       = ptr_q;
    cu_char     = char_code_i;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = '0;
        if (ptr_last) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + CURW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          scr_d      = 1'b0;
          res_char_d = '0;
          tab_more_d = 1'b0;
          if (operation_i == OP_READ) begin
            raddr   = rd_ext[CURW-1:0];
            rd_ok_d = (rd_ext < (CURW+ADDR_W)'(CELLS));
            state_d = S_READ;
          end else if (char_code_i == CH_TAB) begin
            tab_left_d = 2'd3;
            state_d    = S_TAB;
          end else begin
            we       = cu_ctl.write;
            cursor_d = cu_cursor;
            col_d    = cu_col;
            if (cu_ctl.scroll) begin
              ptr_d   = CURW'(COLUMNS);
              pend_d  = 1'b0;
              scr_d   = 1'b1;
              state_d = S_COPY;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_READ: begin
        res_char_d = rd_ok_q ? rdata : '0;
        state_d    = S_DONE;
      end
      S_TAB: begin
        cu_char    = CH_SPACE;
        we         = cu_ctl.write;
        cursor_d   = cu_cursor;
        col_d      = cu_col;
        tab_left_d = tab_left_q - 2'd1;
        tab_more_d = (tab_left_q != 2'd0);
        if (cu_ctl.scroll) begin
          ptr_d   = CURW'(COLUMNS);
          pend_d  = 1'b0;
          scr_d   = 1'b1;
          state_d = S_COPY;
        end else if (tab_left_q == 2'd0) begin
          state_d = S_DONE;
        end
      end
      S_COPY: begin
        raddr  = ptr_q;
        pend_d = 1'b1;
        dst_d  = ptr_q - CURW'(COLUMNS);
        we     = pend_q;
        waddr  = dst_q;
        wdata  = rdata;
        if (ptr_last) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q + CURW'(1);
        end
      end
      S_DRAIN: begin
        we      = 1'b1;
        waddr   = dst_q;
        wdata   = rdata;
        pend_d  = 1'b0;
        ptr_d   = CURW'(CELLS - COLUMNS);
        state_d = S_FILL;
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = CH_SPACE;
        if (ptr_last) begin
          state_d = tab_more_q ? S_TAB : S_DONE;
        end else begin
          ptr_d = ptr_q + CURW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_char_d  = res_char_q;
          out_cur_d   = cursor_q;
          out_scr_d   = scr_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cursor_q    <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      dst_q       <= '0;
      pend_q      <= 1'b0;
      tab_left_q  <= '0;
      tab_more_q  <= 1'b0;
      scr_q       <= 1'b0;
      rd_ok_q     <= 1'b0;
      res_char_q  <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_cur_q   <= '0;
      out_scr_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      dst_q       <= dst_d;
      pend_q      <= pend_d;
      tab_left_q  <= tab_left_d;
      tab_more_q  <= tab_more_d;
      scr_q       <= scr_d;
      rd_ok_q     <= rd_ok_d;
      res_char_q  <= res_char_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_cur_q   <= out_cur_d;
      out_scr_q   <= out_scr_d;
    end
  end

  assign cur_ext      = (CURW+CURSOR_W)'(out_cur_q);
  assign out_valid_o  = out_valid_q;
  assign read_char_o  = out_char_q;
  assign cursor_pos_o = cur_ext[CURSOR_W-1:0];
  assign scrolled_o   = out_scr_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cursor_q} < (CURW+1)'(CELLS)) && (col_q < CLW'(COLUMNS - 1) ||
     col_q == CLW'(COLUMNS - 1)))
    else $error("cursor or column out of range");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("accepted beat not taken into work");

  a_copy_pends_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COPY |=> pend_q)
    else $error("scroll copy lost its pending write");

  a_fill_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL && ptr_last |=> state_q == S_DONE || state_q == S_TAB)
    else $error("row fill did not finish the scroll");

  a_scroll_bottom_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && scr_q |-> cursor_q >= CURW'(CELLS - COLUMNS))
    else $error("scrolled item left cursor above bottom row");

endmodule

// File: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Next-cursor logic for one character: cursor and column update, cell write
// and scroll request.
// ----------------------------------------------------------------------------
module tcw_cursor import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic [$clog2(COLUMNS*ROWS)-1:0] cursor_i,
  input  logic [$clog2(COLUMNS)-1:0]      col_i,
  input  logic [CHAR_W-1:0]               char_i,
  output logic [$clog2(COLUMNS*ROWS)-1:0] cursor_o,
  output logic [$clog2(COLUMNS)-1:0]      col_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0] waddr_o,
  output cur_ctl_t                        ctl_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CURW  = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);

  logic [CURW:0]   inc;
  logic [CURW-1:0] base;
  logic [CURW:0]   nl;
  logic [CLW-1:0]  col_inc;

  assign inc     = {1'b0, cursor_i} + (CURW+1)'(1);
  assign base    = cursor_i - CURW'(col_i);
  assign nl      = {1'b0, base} + (CURW+1)'(COLUMNS);
  assign col_inc = (col_i == CLW'(COLUMNS - 1)) ? '0 : col_i + CLW'(1);

  always_comb begin
    cursor_o = cursor_i;
    col_o    = col_i;
    waddr_o  = cursor_i;
    ctl_o    = '{write: 1'b0, scroll: 1'b0, wdata: char_i};
    case (char_i)
      CH_BACKSPACE: begin
        if (cursor_i != '0) begin
          cursor_o    = cursor_i - CURW'(1);
          col_o       = (col_i == '0) ? CLW'(COLUMNS - 1) : col_i - CLW'(1);
          waddr_o     = cursor_i - CURW'(1);
          ctl_o.write = 1'b1;
          ctl_o.wdata = CH_SPACE;
        end
      end
      CH_NEWLINE: begin
        col_o = '0;
        if (nl == (CURW+1)'(CELLS)) begin
          cursor_o     = base;
          ctl_o.scroll = 1'b1;
        end else begin
          cursor_o = nl[CURW-1:0];
        end
      end
      CH_RETURN: begin
        cursor_o = base;
        col_o    = '0;
      end
      default: begin
        ctl_o.write = 1'b1;
        col_o       = col_inc;
        if (inc == (CURW+1)'(CELLS)) begin
          cursor_o     = CURW'(CELLS - COLUMNS);
          ctl_o.scroll = 1'b1;
        end else begin
          cursor_o = inc[CURW-1:0];
        end
      end
    endcase
  end

endmodule

// File: tb/tb_text_console_char_writer_core.sv
// ----------------------------------------------------------------------------
// tb_text_console_char_writer_core
// Self-checking bench for the text console character writer.
//
// A behavioral screen model (cell array plus cursor) predicts the report of
// every accepted beat: read-back byte, cursor and scroll flag. A directed
// table walks reset contents, backspace at the home cell, control codes,
// bottom-row newline, tabs that scroll at their end and in their middle,
// plain wrap and out-of-range reads. Random traffic weighted toward
// newlines keeps the screen scrolling. Both sides pace themselves in random
// bursts; the final stretch runs without gaps.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer_core import tcw_pkg::*;;

  localparam int COLS         = COLUMNS_DEF;
  localparam int ROWS_N       = ROWS_DEF;
  localparam int CELLS        = COLS * ROWS_N;
  localparam int RANDOM_ITEMS = 270;
  localparam int QUIET_ITEMS  = 60;
  localparam int DIR_ROWS     = 26;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 6_000_000;

  typedef struct packed {
    logic [CHAR_W-1:0]   read_char;
    logic [CURSOR_W-1:0] cursor_pos;
    logic                scrolled;
  } report_t;

  typedef struct packed {
    logic    pinned;
    report_t want;
  } pin_t;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] addr;
    logic [6:0]        reps;
    logic              pinned;
    report_t           want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                operation_i    = OP_PUT;
  logic [CHAR_W-1:0]   char_code_i    = '0;
  logic [ADDR_W-1:0]   read_address_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [CHAR_W-1:0]   read_char_o;
  logic [CURSOR_W-1:0] cursor_pos_o;
  logic                scrolled_o;

  text_console_char_writer_core #(
    .COLUMNS(COLS),
    .ROWS   (ROWS_N)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .char_code_i   (char_code_i),
    .read_address_i(read_address_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_char_o   (read_char_o),
    .cursor_pos_o  (cursor_pos_o),
    .scrolled_o    (scrolled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Screen model
  logic [CHAR_W-1:0] screen [CELLS];
  int unsigned       cursor_cell;

  initial begin
    for (int i = 0; i < CELLS; i++) screen[i] = '0;
    cursor_cell = 0;
  end

  function automatic bit scroll_if_full();
    if (cursor_cell < CELLS) return 1'b0;
    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = CH_SPACE;
    cursor_cell -= COLS;
    return 1'b1;
  endfunction

  function automatic bit console_put(logic [CHAR_W-1:0] c);
    bit s = 1'b0;
    case (c)
      CH_BACKSPACE: begin
        if (cursor_cell > 0) begin
          cursor_cell--;
          if (cursor_cell < CELLS) screen[cursor_cell] = CH_SPACE;
        end
      end
      CH_NEWLINE: begin
        cursor_cell += COLS;
        cursor_cell -= cursor_cell % COLS;
      end
      CH_RETURN: cursor_cell -= cursor_cell % COLS;
      CH_TAB: begin
        for (int k = 0; k < 4; k++) begin
          if (cursor_cell < CELLS) screen[cursor_cell] = CH_SPACE;
          cursor_cell++;
          if (scroll_if_full()) s = 1'b1;
        end
      end
      default: begin
        if (cursor_cell < CELLS) screen[cursor_cell] = c;
        cursor_cell++;
      end
    endcase
    if (scroll_if_full()) s = 1'b1;
    return s;
  endfunction

  function automatic report_t console_step(logic op, logic [CHAR_W-1:0] c,
                                           logic [ADDR_W-1:0] addr);
    report_t r;
    r = '0;
    if (op == OP_READ) begin
      if (addr < CELLS) r.read_char = screen[addr];
    end else begin
      r.scrolled = console_put(c);
    end
    r.cursor_pos = cursor_cell[CURSOR_W-1:0];
    return r;
  endfunction

  // Report tracking
  pin_t    pinned_reports [$];
  report_t due_reports [$];
  int      mismatches = 0;
  bit      quiet = 1'b0;
  pin_t    pin_now;
  report_t calc, got, want;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pin_now = pinned_reports.pop_front();
      calc = console_step(operation_i, char_code_i, read_address_i);
      due_reports.push_back(pin_now.pinned ? pin_now.want : calc);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{read_char_o, cursor_pos_o, scrolled_o};
      if (due_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report with none pending: read_char %0d cursor %0d scrolled %0d",
                 $time, got.read_char, got.cursor_pos, got.scrolled);
      end else begin
        want = due_reports.pop_front();
        if (got.read_char !== want.read_char) begin
          mismatches++;
          $display("%0t: read_char expected %0d, got %0d",
                   $time, want.read_char, got.read_char);
        end
        if (got.cursor_pos !== want.cursor_pos) begin
          mismatches++;
          $display("%0t: cursor_pos expected %0d, got %0d",
                   $time, want.cursor_pos, got.cursor_pos);
        end
        if (got.scrolled !== want.scrolled) begin
          mismatches++;
          $display("%0t: scrolled expected %0d, got %0d",
                   $time, want.scrolled, got.scrolled);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : rx_pacing
    int n;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 17);
      end else begin
        out_ready_i <= 1'b1;
        n = $urandom_range(1, 24);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic send_beat(input logic op, input logic [CHAR_W-1:0] c,
                           input logic [ADDR_W-1:0] addr, input logic pin,
                           input report_t fixed);
    pinned_reports.push_back('{pin, fixed});
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    char_code_i    <= c;
    read_address_i <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_reports.size() != 0) @(posedge clk_i);
  endtask

  dir_row_t directed_rows [DIR_ROWS];

  initial begin : stimulus
    int                r;
    int                a;
    logic              op;
    logic [CHAR_W-1:0] c;
    logic [ADDR_W-1:0] addr;

    directed_rows = '{
      '{OP_READ, 8'd0,         11'd0,    7'd1,  1'b1, '{8'd0,   11'd0,    1'b0}},
      '{OP_PUT,  CH_BACKSPACE, 11'd0,    7'd1,  1'b1, '{8'd0,   11'd0,    1'b0}},
      '{OP_PUT,  8'd65,        11'd0,    7'd1,  1'b1, '{8'd0,   11'd1,    1'b0}},
      '{OP_PUT,  8'd255,       11'd2047, 7'd1,  1'b1, '{8'd0,   11'd2,    1'b0}},
      '{OP_PUT,  8'd0,         11'd0,    7'd1,  1'b1, '{8'd0,   11'd3,    1'b0}},
      '{OP_READ, 8'd255,       11'd0,    7'd1,  1'b1, '{8'd65,  11'd3,    1'b0}},
      '{OP_READ, 8'd0,         11'd1,    7'd1,  1'b1, '{8'd255, 11'd3,    1'b0}},
      '{OP_PUT,  CH_BACKSPACE, 11'd0,    7'd1,  1'b1, '{8'd0,   11'd2,    1'b0}},
      '{OP_READ, 8'd0,         11'd2,    7'd1,  1'b1, '{8'd32,  11'd2,    1'b0}},
      '{OP_PUT,  CH_TAB,       11'd0,    7'd1,  1'b1, '{8'd0,   11'd6,    1'b0}},
      '{OP_PUT,  CH_RETURN,    11'd0,    7'd1,  1'b1, '{8'd0,   11'd0,    1'b0}},
      '{OP_PUT,  CH_NEWLINE,   11'd0,    7'd24, 1'b1, '{8'd0,   11'd1920, 1'b0}},
      '{OP_READ, 8'd0,         11'd1999, 7'd1,  1'b1, '{8'd0,   11'd1920, 1'b0}},
      '{OP_PUT,  CH_NEWLINE,   11'd0,    7'd1,  1'b1, '{8'd0,   11'd1920, 1'b1}},
      '{OP_READ, 8'd0,         11'd1920, 7'd1,  1'b1, '{8'd32,  11'd1920, 1'b0}},
      '{OP_PUT,  8'd120,       11'd0,    7'd76, 1'b0, '{8'd0,   11'd0,    1'b0}},
      '{OP_PUT,  CH_TAB,       11'd0,    7'd1,  1'b1, '{8'd0,   11'd1920, 1'b1}},
      '{OP_READ, 8'd0,         11'd1840, 7'd1,  1'b1, '{8'd120, 11'd1920, 1'b0}},
      '{OP_PUT,  8'd120,       11'd0,    7'd78, 1'b0, '{8'd0,   11'd0,    1'b0}},
      '{OP_PUT,  CH_TAB,       11'd0,    7'd1,  1'b1, '{8'd0,   11'd1922, 1'b1}},
      '{OP_PUT,  CH_RETURN,    11'd0,    7'd1,  1'b1, '{8'd0,   11'd1920, 1'b0}},
      '{OP_PUT,  8'd254,       11'd0,    7'd80, 1'b1, '{8'd0,   11'd1920, 1'b1}},
      '{OP_READ, 8'd0,         11'd1919, 7'd1,  1'b1, '{8'd254, 11'd1920, 1'b0}},
      '{OP_PUT,  CH_BACKSPACE, 11'd0,    7'd1,  1'b1, '{8'd0,   11'd1919, 1'b0}},
      '{OP_READ, 8'd0,         11'd1919, 7'd1,  1'b1, '{8'd32,  11'd1919, 1'b0}},
      '{OP_READ, 8'd0,         11'd2047, 7'd1,  1'b1, '{8'd0,   11'd1919, 1'b0}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        sender_gap();
        send_beat(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].addr,
                  directed_rows[i].pinned && (k == directed_rows[i].reps - 1),
                  directed_rows[i].want);
      end
    end
    hold_until_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
      if (i == RANDOM_ITEMS / 2) hold_until_drained();
      r    = $urandom_range(0, 99);
      op   = (r < 25) ? OP_READ : OP_PUT;
      c    = CHAR_W'($urandom_range(0, 255));
      addr = ADDR_W'($urandom_range(0, 2047));
      if (op == OP_READ) begin
        a = $urandom_range(0, 99);
        if (a >= 85)      addr = ADDR_W'($urandom_range(0, 2 * COLS - 1));
        else if (a >= 70) addr = ADDR_W'($urandom_range(CELLS, 2047));
        else if (a >= 40) addr = ADDR_W'($urandom_range(CELLS - 4 * COLS, CELLS - 1));
      end else if (r < 45) begin
        c = CH_NEWLINE;
      end else if (r < 51) begin
        c = CH_TAB;
      end else if (r < 58) begin
        c = CH_BACKSPACE;
      end else if (r < 62) begin
        c = CH_RETURN;
      end else if (r < 85) begin
        c = CHAR_W'($urandom_range(32, 126));
      end
      sender_gap();
      send_beat(op, c, addr, 1'b0, '0);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
